>>> rtl/halo_isolation_test_top_defines.svh
// Assertion macros shared by the halo isolation test RTL.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef HALO_ISOLATION_TEST_TOP_DEFINES_SVH
`define HALO_ISOLATION_TEST_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> rtl/hit_pkg.sv
// Types and codes for the halo isolation test block.
// No dependencies; imported by hit_front, hit_back and the top level.
package hit_pkg;
   localparam logic [1:0] KIND_CLEAR  = 2'd0;
   localparam logic [1:0] KIND_APPEND = 2'd1;
   localparam logic [1:0] KIND_QUERY  = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;
   localparam logic [1:0] OP_NOP    = 2'd3;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_FULL       = 2'd1;
   localparam logic [1:0] STATUS_NOT_STORED = 2'd2;

   localparam logic [1:0] CSR_ISO_FACTOR = 2'd0;
   localparam logic [1:0] CSR_BOX_LENGTH = 2'd1;

   localparam logic [15:0] ISO_FACTOR_RESET = 16'd256;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic signed [23:0] pos_z;
      logic [31:0]        halo_mass;
      logic [23:0]        halo_radius;
      logic [9:0]         query_index;
   } req_type;

   typedef struct packed {
      logic        isolated;
      logic [10:0] stored_count;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic signed [23:0] pos_z;
      logic [31:0]        mass;
      logic [23:0]        radius;
   } halo_entry_type;

   typedef struct packed {
      logic [1:0]     op;
      halo_entry_type entry;
      logic [9:0]     query_index;
   } cmd_type;
endpackage

>>> rtl/hit_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hit_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

>>> rtl/hit_queue.sv
// Two-entry first-in first-out queue of a generic payload width.
// No dependencies; used for the command queue and the result queue.
module hit_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

>>> rtl/hit_front.sv
// Front end: classifies each request into a command and queues it.
// Depends on hit_pkg and hit_queue.
module hit_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  hit_pkg::req_type req_data,
   output logic             full,
   input  logic             cmd_pop,
   output hit_pkg::cmd_type cmd_data,
   output logic             cmd_valid
);
   import hit_pkg::*;

   cmd_type cmd_in;
   logic    cmd_empty;

   always_comb begin
      cmd_in.entry.pos_x  = req_data.pos_x;
      cmd_in.entry.pos_y  = req_data.pos_y;
      cmd_in.entry.pos_z  = req_data.pos_z;
      cmd_in.entry.mass   = req_data.halo_mass;
      cmd_in.entry.radius = req_data.halo_radius;
      cmd_in.query_index  = req_data.query_index;
      unique case (req_data.kind)
         KIND_CLEAR:  cmd_in.op = OP_CLEAR;
         KIND_APPEND: cmd_in.op = OP_APPEND;
         KIND_QUERY:  cmd_in.op = OP_QUERY;
         KIND_UNUSED: cmd_in.op = OP_NOP;
         default:     cmd_in.op = OP_NOP;
      endcase
   end

   hit_queue #(.WIDTH($bits(cmd_type))) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (cmd_in),
      .full      (full),
      .pop       (cmd_pop),
      .pop_data  (cmd_data),
      .empty     (cmd_empty)
   );

   assign cmd_valid = !cmd_empty;
endmodule

>>> rtl/hit_back.sv
// Back end: holds the halo store and count, executes commands and scans for queries.
// Depends on hit_pkg, hit_ram and the assertion macro header.
`include "halo_isolation_test_top_defines.svh"
module hit_back #(
   parameter int MAX_HALOS = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  hit_pkg::cmd_type cmd_data,
   output logic             cmd_pop,
   input  logic [15:0]      iso_factor,
   input  logic [22:0]      box_length,
   input  logic             rsp_full,
   output logic             rsp_push,
   output hit_pkg::rsp_type rsp_data
);
   import hit_pkg::*;

   localparam int AW  = $clog2(MAX_HALOS);
   localparam int CW  = $clog2(MAX_HALOS + 1);
   localparam int QW  = (CW > 10) ? CW : 10;
   localparam int OW  = (CW > 11) ? CW : 11;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_RDQ   = 3'd1;
   localparam logic [2:0] ST_LATCH = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;
   localparam logic [2:0] ST_RESP  = 3'd5;

   logic [2:0]     state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  qi_ff, qi_in;
   logic [CW-1:0]  j_ff, j_in;
   logic           hit_ff, hit_in;
   logic [QW-1:0]  q_ext;
   logic [OW-1:0]  count_out;
   logic [AW-1:0]  rd_addr;
   halo_entry_type rd_entry;
   logic           wr_en;
   logic           busy;

   halo_entry_type h_ff;
   logic [39:0]    fr_ff;

   // Scan pipeline.
   logic               vb_ff, vc_ff, vd_ff, ve_ff;
   logic [CW-1:0]      jb_ff;
   logic signed [24:0] dx_ff, dy_ff, dz_ff;
   logic               cand_c_ff, cand_d_ff, cand_e_ff;
   logic [40:0]        reach_ff;
   logic signed [25:0] wx_ff, wy_ff, wz_ff;
   logic [39:0]        hh_ff;
   logic [40:0]        hl_ff;
   logic [41:0]        ll_ff;
   logic [47:0]        sx_ff, sy_ff, sz_ff;
   logic [81:0]        r2_ff;

   logic               above, heavy;
   logic signed [25:0] box_s;
   logic [49:0]        d2;
   logic               closer;

   assign q_ext     = QW'(cmd_data.query_index);
   assign count_out = OW'(count_ff);
   assign busy      = vb_ff || vc_ff || vd_ff || ve_ff;
   assign wr_en     = cmd_pop && (cmd_data.op == OP_APPEND)
                      && (count_ff != CW'(MAX_HALOS));
   assign rd_addr   = (state_ff == ST_SCAN) ? j_ff[AW-1:0] : qi_ff[AW-1:0];

   hit_ram #(.WIDTH($bits(halo_entry_type)), .DEPTH(MAX_HALOS)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (cmd_data.entry),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      qi_in    = qi_ff;
      j_in     = j_ff;
      hit_in   = hit_ff;
      cmd_pop  = 1'b0;
      rsp_push = 1'b0;
      rsp_data.isolated     = 1'b0;
      rsp_data.stored_count = count_out[10:0];
      rsp_data.status       = STATUS_OK;
      if (ve_ff && cand_e_ff && closer) begin
         hit_in = 1'b1;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && !rsp_full) begin
               cmd_pop = 1'b1;
               unique case (cmd_data.op)
                  OP_CLEAR: begin
                     count_in = '0;
                     rsp_push = 1'b1;
                     rsp_data.stored_count = 11'd0;
                  end
                  OP_APPEND: begin
                     rsp_push = 1'b1;
                     if (count_ff == CW'(MAX_HALOS)) begin
                        rsp_data.status = STATUS_FULL;
                     end else begin
                        count_in = count_ff + 1'b1;
                        rsp_data.stored_count = count_out[10:0] + 11'd1;
                     end
                  end
                  OP_QUERY: begin
                     if (q_ext >= QW'(count_ff)) begin
                        rsp_push = 1'b1;
                        rsp_data.status = STATUS_NOT_STORED;
                     end else begin
                        qi_in    = q_ext[CW-1:0];
                        state_in = ST_RDQ;
                     end
                  end
                  default: begin
                     rsp_push = 1'b1;
                  end
               endcase
            end
         end
         ST_RDQ: begin
            state_in = ST_LATCH;
         end
         ST_LATCH: begin
            j_in     = '0;
            hit_in   = 1'b0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            j_in = j_ff + 1'b1;
            if (j_ff + 1'b1 == count_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!busy) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               rsp_data.isolated = !hit_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         vb_ff    <= 1'b0;
         vc_ff    <= 1'b0;
         vd_ff    <= 1'b0;
         ve_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         vb_ff    <= (state_ff == ST_SCAN);
         vc_ff    <= vb_ff;
         vd_ff    <= vc_ff;
         ve_ff    <= vd_ff;
      end
   end

   always_ff @(posedge clock) begin
      qi_ff  <= qi_in;
      j_ff   <= j_in;
      hit_ff <= hit_in;
      jb_ff  <= j_ff;
      if (state_ff == ST_LATCH) begin
         h_ff  <= rd_entry;
         fr_ff <= 40'(iso_factor) * 40'(rd_entry.radius);
      end
   end

   // Stage with the neighbor entry: differences, rank test and reach.
   always_comb begin
      above = (rd_entry.mass > h_ff.mass)
              || ((rd_entry.mass == h_ff.mass) && (jb_ff < qi_ff));
      heavy = {rd_entry.mass, 1'b0} > {1'b0, h_ff.mass};
   end

   always_ff @(posedge clock) begin
      dx_ff     <= {h_ff.pos_x[23], h_ff.pos_x} - {rd_entry.pos_x[23], rd_entry.pos_x};
      dy_ff     <= {h_ff.pos_y[23], h_ff.pos_y} - {rd_entry.pos_y[23], rd_entry.pos_y};
      dz_ff     <= {h_ff.pos_z[23], h_ff.pos_z} - {rd_entry.pos_z[23], rd_entry.pos_z};
      cand_c_ff <= above && heavy;
      reach_ff  <= 41'(fr_ff) + 41'({rd_entry.radius, 8'd0});
   end

   // Periodic wrap and reach partial products.
   assign box_s = signed'({3'd0, box_length});

   function automatic logic signed [25:0] wrap_diff(input logic signed [24:0] d,
                                                    input logic signed [25:0] b);
      logic signed [25:0] d_w;
      logic signed [25:0] two_d;
      d_w   = {d[24], d};
      two_d = {d, 1'b0};
      wrap_diff = d_w;
      if (b != 26'sd0) begin
         if (two_d > b) begin
            wrap_diff = d_w - b;
         end else if (two_d < -b) begin
            wrap_diff = d_w + b;
         end
      end
   endfunction

   always_ff @(posedge clock) begin
      wx_ff     <= wrap_diff(dx_ff, box_s);
      wy_ff     <= wrap_diff(dy_ff, box_s);
      wz_ff     <= wrap_diff(dz_ff, box_s);
      hh_ff     <= 40'(reach_ff[40:21]) * 40'(reach_ff[40:21]);
      hl_ff     <= 41'(reach_ff[40:21]) * 41'(reach_ff[20:0]);
      ll_ff     <= 42'(reach_ff[20:0]) * 42'(reach_ff[20:0]);
      cand_d_ff <= cand_c_ff;
   end

   // Squares and reassembled squared reach.
   always_ff @(posedge clock) begin
      sx_ff     <= 48'(wx_ff * wx_ff);
      sy_ff     <= 48'(wy_ff * wy_ff);
      sz_ff     <= 48'(wz_ff * wz_ff);
      r2_ff     <= (82'(hh_ff) << 42) + (82'(hl_ff) << 22) + 82'(ll_ff);
      cand_e_ff <= cand_d_ff;
   end

   assign d2     = 50'(sx_ff) + 50'(sy_ff) + 50'(sz_ff);
   assign closer = (82'(d2) << 16) < r2_ff;

   `ASSERT_IMPLIES(a_push_room, clock, reset, rsp_push, !rsp_full, "result pushed while full")
   `ASSERT_IMPLIES(a_scan_bound, clock, reset, state_ff == ST_SCAN, j_ff < count_ff,
                   "scan index beyond stored count")
   `ASSERT_IMPLIES(a_resp_drained, clock, reset, state_ff == ST_RESP, !busy,
                   "query answered with comparisons in flight")
endmodule

>>> rtl/halo_isolation_test_top.sv
// Halo isolation test: a query is answered after a scan that reads one stored
// halo per cycle through a single memory port into a four-stage compare
// pipeline. Clear, append, unused kinds and rejected queries are answered
// from the idle state. Synchronous active-high reset empties the store and queues
// and restores the register defaults; store contents are not cleared.
// Top level: configuration registers, front end, back end and result queue.
module halo_isolation_test_top #(
   parameter int MAX_HALOS = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  hit_pkg::req_type req_data,
   output logic             full,
   output logic             empty,
   input  logic             pop,
   output hit_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [22:0]      csr_wdata
);
   import hit_pkg::*;

   logic [15:0] iso_factor_ff;
   logic [22:0] box_length_ff;
   cmd_type     cmd_data;
   logic        cmd_valid;
   logic        cmd_pop;
   logic        rsp_push;
   logic        rsp_full;
   rsp_type     rsp_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         iso_factor_ff <= ISO_FACTOR_RESET;
         box_length_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ISO_FACTOR: iso_factor_ff <= csr_wdata[15:0];
            CSR_BOX_LENGTH: box_length_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   hit_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_data  (req_data),
      .full      (full),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data),
      .cmd_valid (cmd_valid)
   );

   hit_back #(.MAX_HALOS(MAX_HALOS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_data   (cmd_data),
      .cmd_pop    (cmd_pop),
      .iso_factor (iso_factor_ff),
      .box_length (box_length_ff),
      .rsp_full   (rsp_full),
      .rsp_push   (rsp_push),
      .rsp_data   (rsp_in)
   );

   hit_queue #(.WIDTH($bits(rsp_type))) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_data),
      .empty     (empty)
   );
endmodule
